@@ src/cbp_pkg.sv @@
// shared types and constants of the coefficient bit packer
package cbp_pkg;

    localparam int MAX_POLY_COEFFS = 1024;
    localparam int MAX_COEFF_WIDTH = 17;

    localparam int BYTE_W     = 8;
    localparam int COEFF_W    = 18;
    localparam int ACC_W      = 24;
    localparam int HELD_W     = 5;
    localparam int WIDTH_W    = 5;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = (MAX_POLY_COEFFS > 1) ? $clog2(MAX_POLY_COEFFS) : 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    // power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef logic [MAX_COEFF_WIDTH-1:0] t_mask;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNPACK_MODE = 4'd0,
        CFG_COEFF_WIDTH = 4'd1,
        CFG_SIGN_EXTEND = 4'd2,
        CFG_POLY_LENGTH = 4'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               unpack;
        logic               sign_ext;
        logic [WIDTH_W-1:0] width;
        t_mask              mask;
        logic [LEN_W-1:0]   last_idx;
    } t_cfg;

endpackage

@@ src/cbp_front.sv @@
// input side: word acceptance, field selection and masking, short work queue
module cbp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cbp_pkg::t_cfg                  i_cfg,
    input  logic                           push,
    output logic                           full,
    input  logic signed [cbp_pkg::COEFF_W-1:0] i_coeff_in,
    input  logic [cbp_pkg::BYTE_W-1:0]     i_byte_in,
    output logic                           o_avail,
    output cbp_pkg::t_mask                 o_data,
    input  logic                           i_take
);
    import cbp_pkg::*;

    t_mask                 r_data [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]     r_count, n_count;
    logic                  accept;
    logic                  take;
    t_mask                 work;

    assign full    = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_data  = r_data[r_rd_ptr];
    assign accept  = push && !full;
    assign take    = i_take && o_avail;

    always_comb begin
        if (i_cfg.unpack) begin
            work = MAX_COEFF_WIDTH'(i_byte_in);
        end else begin
            work = i_coeff_in[MAX_COEFF_WIDTH-1:0] & i_cfg.mask;
        end
    end

    always_comb begin
        n_wr_ptr = accept ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = take ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (accept && !take) begin
            n_count = r_count + 1'b1;
        end else if (take && !accept) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data[r_wr_ptr] <= work;
        end
    end

endmodule

@@ src/cbp_back.sv @@
// bit accumulator engine and result register
module cbp_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cbp_pkg::t_cfg                      i_cfg,
    input  logic                               i_clr,
    input  logic                               i_avail,
    input  cbp_pkg::t_mask                     i_data,
    output logic                               o_take,
    output logic                               empty,
    input  logic                               pop,
    output logic [cbp_pkg::BYTE_W-1:0]         o_byte_out,
    output logic signed [cbp_pkg::COEFF_W-1:0] o_coeff_out,
    output logic                               o_last_out
);
    import cbp_pkg::*;

    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [HELD_W-1:0]  r_held, n_held;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_last_item, n_last_item;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic [COEFF_W-1:0] r_coeff;
    logic               r_last;

    logic               out_free;
    logic               emit;
    logic               e_last;
    logic [BYTE_W-1:0]  e_byte;
    logic [COEFF_W-1:0] e_coeff;
    t_mask              v;
    t_mask              top_bit;
    logic               neg;
    logic [HELD_W-1:0]  held_sub8;
    logic [HELD_W-1:0]  held_subw;
    logic [HELD_W-1:0]  held_rest;
    logic [HELD_W-1:0]  held_addw;
    logic [HELD_W-1:0]  held_add8;
    logic               at_last;

    assign out_free = !r_out_valid || pop;
    assign empty    = !r_out_valid;
    assign o_byte_out  = r_byte;
    assign o_coeff_out = r_coeff;
    assign o_last_out  = r_last;

    assign v         = r_acc[MAX_COEFF_WIDTH-1:0] & i_cfg.mask;
    assign top_bit   = i_cfg.mask ^ (i_cfg.mask >> 1);
    assign neg       = i_cfg.sign_ext && (|(v & top_bit));
    assign held_sub8 = r_held - HELD_W'(BYTE_W);
    assign held_subw = r_held - i_cfg.width;
    assign held_rest = (r_held >= HELD_W'(BYTE_W)) ? held_sub8 : '0;
    assign held_addw = r_held + i_cfg.width;
    assign held_add8 = r_held + HELD_W'(BYTE_W);
    assign at_last   = (LEN_W'(r_cnt) == i_cfg.last_idx);

    always_comb begin
        n_acc       = r_acc;
        n_held      = r_held;
        n_cnt       = r_cnt;
        n_busy      = r_busy;
        n_last_item = r_last_item;
        o_take      = 1'b0;
        emit        = 1'b0;
        e_last      = 1'b0;
        e_byte      = '0;
        e_coeff     = '0;
        if (r_busy) begin
            if (out_free) begin
                emit = 1'b1;
                if (!i_cfg.unpack) begin
                    e_byte = r_acc[BYTE_W-1:0];
                    n_acc  = r_acc >> BYTE_W;
                    n_held = held_rest;
                    if (r_last_item && held_rest == '0) begin
                        e_last      = 1'b1;
                        n_busy      = 1'b0;
                        n_last_item = 1'b0;
                        n_acc       = '0;
                    end else begin
                        n_busy = r_last_item || (held_rest >= HELD_W'(BYTE_W));
                    end
                end else begin
                    e_coeff = {1'b0, v} | (neg ? ~{1'b0, i_cfg.mask} : '0);
                    n_acc   = r_acc >> i_cfg.width;
                    n_held  = held_subw;
                    if (at_last) begin
                        e_last = 1'b1;
                        n_acc  = '0;
                        n_held = '0;
                        n_cnt  = '0;
                        n_busy = 1'b0;
                    end else begin
                        n_cnt  = r_cnt + 1'b1;
                        n_busy = (held_subw >= i_cfg.width);
                    end
                end
            end
        end else if (i_avail) begin
            o_take = 1'b1;
            n_acc  = r_acc | (ACC_W'(i_data) << r_held);
            if (!i_cfg.unpack) begin
                n_held = held_addw;
                if (at_last) begin
                    n_cnt       = '0;
                    n_last_item = 1'b1;
                    n_busy      = 1'b1;
                end else begin
                    n_cnt  = r_cnt + 1'b1;
                    n_busy = (held_addw >= HELD_W'(BYTE_W));
                end
            end else begin
                n_held = held_add8;
                n_busy = (held_add8 >= i_cfg.width);
            end
        end
        if (i_clr) begin
            n_acc       = '0;
            n_held      = '0;
            n_cnt       = '0;
            n_busy      = 1'b0;
            n_last_item = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_held      <= '0;
            r_cnt       <= '0;
            r_busy      <= 1'b0;
            r_last_item <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_held      <= n_held;
            r_cnt       <= n_cnt;
            r_busy      <= n_busy;
            r_last_item <= n_last_item;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte  <= e_byte;
            r_coeff <= e_coeff;
            r_last  <= e_last;
        end
    end

    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc >> r_held) == '0)
        else $error("accumulator holds bits above the fill level");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_W'(ACC_W))
        else $error("fill level beyond accumulator width");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && e_last && !i_clr) |=> (r_held == '0 && r_cnt == '0 && !r_busy))
        else $error("polynomial end did not clear the stream state");

    a_unpack_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_cfg.unpack) |-> (r_held >= i_cfg.width))
        else $error("unpack engine busy without a full coefficient");

endmodule

@@ src/coefficient_bit_packer.sv @@
// top level of the coefficient bit packer: configuration registers and the two halves
//
// Pack mode (unpack_mode 0): push coefficients on the input queue, pop packed bytes.
// Unpack mode (unpack_mode 1): push bytes, pop coefficients (zero- or sign-extended).
// Input: push/full, a word is taken when push is high and full is low.
// Output: empty/pop, the oldest result sits on the result ports while empty is low
// and leaves when pop is high.
// Configuration: i_cfg_valid/o_cfg_ready with index and data; ready is always high.
// A write to a listed register restarts the polynomial. Write only while idle.
// The first result of a word passes from the input queue through the engine accumulator into the result register.
// Throughput: the engine loads a word in a step of its own, then emits one result per cycle
// while the result register is free, and takes no new word until it is done;
// a 2-entry queue in front takes new words while the engine works.
// Reset restores the register defaults (pack, width 10, zero-extend, length 512)
// and empties the queue, the accumulator and the result register.
// A stalled receiver holds the result register; the engine and then the input
// queue fill, and full rises.
module coefficient_bit_packer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [cbp_pkg::COEFF_W-1:0]    i_coeff_in,
    input  logic [cbp_pkg::BYTE_W-1:0]            i_byte_in,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [cbp_pkg::BYTE_W-1:0]            o_byte_out,
    output logic signed [cbp_pkg::COEFF_W-1:0]    o_coeff_out,
    output logic                                  o_last_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import cbp_pkg::*;

    logic               r_unpack_mode;
    logic [WIDTH_W-1:0] r_coeff_width;
    logic               r_sign_extend;
    logic [LEN_W-1:0]   r_poly_length;

    logic               cfg_wr;
    logic               cfg_clr;
    logic [WIDTH_W-1:0] width_eff;
    logic [LEN_W-1:0]   len_eff;
    t_mask              mask;
    t_cfg               cfg;
    logic               q_avail;
    t_mask              q_data;
    logic               q_take;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_clr     = cfg_wr && (i_cfg_index inside {CFG_UNPACK_MODE, CFG_COEFF_WIDTH,
                                                        CFG_SIGN_EXTEND, CFG_POLY_LENGTH});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unpack_mode <= 1'b0;
            r_coeff_width <= WIDTH_W'(10);
            r_sign_extend <= 1'b0;
            r_poly_length <= LEN_W'(512);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_UNPACK_MODE: r_unpack_mode <= i_cfg_data[0];
                CFG_COEFF_WIDTH: r_coeff_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_SIGN_EXTEND: r_sign_extend <= i_cfg_data[0];
                CFG_POLY_LENGTH: r_poly_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_coeff_width == '0) begin
            width_eff = WIDTH_W'(1);
        end else if (int'(r_coeff_width) > MAX_COEFF_WIDTH) begin
            width_eff = WIDTH_W'(MAX_COEFF_WIDTH);
        end else begin
            width_eff = r_coeff_width;
        end
        if (r_poly_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(r_poly_length) > MAX_POLY_COEFFS) begin
            len_eff = LEN_W'(MAX_POLY_COEFFS);
        end else begin
            len_eff = r_poly_length;
        end
        for (int i = 0; i < MAX_COEFF_WIDTH; i++) begin
            mask[i] = (i < int'(width_eff));
        end
        cfg.unpack   = r_unpack_mode;
        cfg.sign_ext = r_sign_extend;
        cfg.width    = width_eff;
        cfg.mask     = mask;
        cfg.last_idx = len_eff - 1'b1;
    end

    cbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .push       (push),
        .full       (full),
        .i_coeff_in (i_coeff_in),
        .i_byte_in  (i_byte_in),
        .o_avail    (q_avail),
        .o_data     (q_data),
        .i_take     (q_take)
    );

    cbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_clr       (cfg_clr),
        .i_avail     (q_avail),
        .i_data      (q_data),
        .o_take      (q_take),
        .empty       (empty),
        .pop         (pop),
        .o_byte_out  (o_byte_out),
        .o_coeff_out (o_coeff_out),
        .o_last_out  (o_last_out)
    );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench: drives coefficients and bytes through the packer and checks every word
module testbench;
    import cbp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 4'd15;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 300;

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_val;
        logic [COEFF_W-1:0] coeff_val;
        logic               last;
    } t_stream_word;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        push        = 1'b0;
    logic                        full;
    logic signed [COEFF_W-1:0]   i_coeff_in  = '0;
    logic [BYTE_W-1:0]           i_byte_in   = '0;
    logic                        empty;
    logic                        pop         = 1'b0;
    logic [BYTE_W-1:0]           o_byte_out;
    logic signed [COEFF_W-1:0]   o_coeff_out;
    logic                        o_last_out;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data  = '0;

    logic               mode_unpack;
    logic [WIDTH_W-1:0] reg_width;
    logic               reg_sign;
    logic [LEN_W-1:0]   reg_length;
    logic [ACC_W-1:0]   acc_bits;
    logic [HELD_W-1:0]  held_bits;
    logic [LEN_W-1:0]   coeffs_done;

    t_stream_word awaited_words[$];

    int errors        = 0;
    int words_in      = 0;
    int words_out     = 0;
    int settings_used = 0;
    int full_cycles   = 0;
    int rx_hold_cycles = 0;
    bit tx_gaps   = 1'b0;
    bit rx_stalls = 1'b0;

    coefficient_bit_packer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_coeff_in  (i_coeff_in),
        .i_byte_in   (i_byte_in),
        .empty       (empty),
        .pop         (pop),
        .o_byte_out  (o_byte_out),
        .o_coeff_out (o_coeff_out),
        .o_last_out  (o_last_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned clamp_width(input int unsigned w);
        if (w == 0) return 1;
        if (w > MAX_COEFF_WIDTH) return MAX_COEFF_WIDTH;
        return w;
    endfunction

    function automatic int unsigned clamp_length(input int unsigned len);
        if (len == 0) return 1;
        if (len > MAX_POLY_COEFFS) return MAX_POLY_COEFFS;
        return len;
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    task automatic clear_stream();
        acc_bits    = '0;
        held_bits   = '0;
        coeffs_done = '0;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_UNPACK_MODE: mode_unpack = value[0];
            CFG_COEFF_WIDTH: reg_width = value[WIDTH_W-1:0];
            CFG_SIGN_EXTEND: reg_sign = value[0];
            CFG_POLY_LENGTH: reg_length = value[LEN_W-1:0];
            default: return;
        endcase
        clear_stream();
    endtask

    // expected words caused by one accepted input word
    task automatic advance_stream(input logic [COEFF_W-1:0] coeff, input logic [BYTE_W-1:0] octet);
        int unsigned w;
        int unsigned len;
        int unsigned mask;
        int unsigned v;
        bit ending;
        t_stream_word word;
        w    = clamp_width(32'(reg_width));
        len  = clamp_length(32'(reg_length));
        mask = (32'd1 << w) - 32'd1;
        word = '0;
        if (!mode_unpack) begin
            ending    = (32'(coeffs_done) + 32'd1 >= len);
            v         = 32'(coeff) & mask;
            acc_bits  = acc_bits | ACC_W'(v << held_bits);
            held_bits = held_bits + HELD_W'(w);
            while (held_bits >= HELD_W'(8)) begin
                word.byte_val = acc_bits[7:0];
                acc_bits      = acc_bits >> 8;
                held_bits     = held_bits - HELD_W'(8);
                word.last     = ending && (held_bits == '0);
                awaited_words.push_back(word);
            end
            coeffs_done = coeffs_done + 1'b1;
            if (ending) begin
                if (held_bits != '0) begin
                    word.byte_val = acc_bits[7:0];
                    word.last     = 1'b1;
                    awaited_words.push_back(word);
                end
                clear_stream();
            end
        end else begin
            acc_bits  = acc_bits | (ACC_W'(octet) << held_bits);
            held_bits = held_bits + HELD_W'(8);
            while (32'(held_bits) >= w && 32'(coeffs_done) < len) begin
                v         = 32'(acc_bits) & mask;
                acc_bits  = acc_bits >> w;
                held_bits = held_bits - HELD_W'(w);
                if (reg_sign && (((v >> (w - 32'd1)) & 32'd1) != 32'd0)) v = v | ~mask;
                coeffs_done    = coeffs_done + 1'b1;
                word.coeff_val = v[COEFF_W-1:0];
                word.last      = (32'(coeffs_done) >= len);
                awaited_words.push_back(word);
                if (word.last) begin
                    clear_stream();
                    break;
                end
            end
        end
    endtask

    task automatic send_word(input logic [COEFF_W-1:0] coeff, input logic [BYTE_W-1:0] octet);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_coeff_in <= coeff;
        i_byte_in  <= octet;
        do @(posedge i_clk); while (full);
        advance_stream(coeff, octet);
        words_in++;
    endtask

    // leaves valid high, the caller lowers it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, value);
    endtask

    task automatic set_stream(input int unsigned mode, input int unsigned width,
                              input int unsigned sign, input int unsigned length);
        write_reg(CFG_UNPACK_MODE, mode[CFG_DATA_W-1:0]);
        write_reg(CFG_COEFF_WIDTH, width[CFG_DATA_W-1:0]);
        write_reg(CFG_SIGN_EXTEND, sign[CFG_DATA_W-1:0]);
        write_reg(CFG_POLY_LENGTH, length[CFG_DATA_W-1:0]);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain_stream();
        push <= 1'b0;
        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_stream_word want;
        if (i_rst_n && push && full) full_cycles++;
        if (i_rst_n && pop && !empty) begin
            words_out++;
            if (awaited_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word expected none got byte %h coeff %h last %b",
                         $time, o_byte_out, o_coeff_out, o_last_out);
            end else begin
                want = awaited_words.pop_front();
                check_field("byte_out", 32'(want.byte_val), 32'(o_byte_out));
                check_field("coeff_out", 32'(want.coeff_val), 32'({o_coeff_out}));
                check_field("last_out", 32'(want.last), 32'(o_last_out));
            end
        end
    end

    initial begin : receiver
        int hold;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                pop <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else if (!rx_stalls || $urandom_range(0, 99) < 60) begin
                pop <= 1'b1;
            end else begin
                pop <= 1'b0;
                hold = pick_gap();
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    task automatic test_pack_extremes();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b1;
        set_stream(0, 17, 0, 3);
        send_word(18'h1FFFF, 8'h00);
        send_word(18'h20000, 8'hFF);
        send_word(18'h3FFFF, 8'h5A);
        drain_stream();
        // last coefficient ends on a byte boundary
        set_stream(0, 8, 0, 2);
        send_word(18'h000FF, 8'h00);
        send_word(18'h3FF00, 8'hFF);
        drain_stream();
    endtask

    task automatic test_register_edges();
        set_stream(0, 0, 1, 0);
        send_word(18'h3FFFE, 8'hFF);
        send_word(18'h00001, 8'h00);
        drain_stream();
        set_stream(0, 'h7FF, 1, 'h7FF);
        send_word(18'h2AAAA, 8'h80);
        send_word(18'h15555, 8'h01);
        drain_stream();
        // unlisted index must not restart the polynomial
        write_reg(CFG_UNLISTED, 11'h7FF);
        i_cfg_valid <= 1'b0;
        send_word(18'h3FFFF, 8'h7F);
        send_word(18'h00000, 8'hFE);
        drain_stream();
        set_stream('h7FE, 'h7E3, 'h7FE, 2);
        send_word(18'h00005, 8'h33);
        send_word(18'h3FFFA, 8'hCC);
        drain_stream();
    endtask

    task automatic test_unpack_extremes();
        set_stream(1, 1, 1, 8);
        send_word(18'h3FFFF, 8'hA5);
        drain_stream();
        set_stream(1, 17, 1, 2);
        send_word(18'h00000, 8'hFF);
        send_word(18'h00000, 8'hFF);
        send_word(18'h00000, 8'h01);
        send_word(18'h00000, 8'h00);
        send_word(18'h00000, 8'h02);
        drain_stream();
        set_stream(1, 17, 0, 1);
        send_word(18'h12345, 8'h00);
        send_word(18'h12345, 8'h00);
        send_word(18'h12345, 8'hFF);
        drain_stream();
        // padding bits after the last coefficient are dropped
        set_stream(1, 5, 0, 3);
        send_word(18'h00000, 8'hFF);
        send_word(18'h00000, 8'h80);
        drain_stream();
    endtask

    task automatic test_backpressure();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        set_stream(0, 17, 0, 16);
        rx_hold_cycles = LONG_HOLD;
        repeat (24) send_word(COEFF_W'($urandom_range(0, 18'h3FFFF)),
                              BYTE_W'($urandom_range(0, 255)));
        drain_stream();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        repeat (8) send_word(COEFF_W'($urandom_range(0, 18'h3FFFF)),
                             BYTE_W'($urandom_range(0, 255)));
        drain_stream();
    endtask

    task automatic test_random_streams();
        int unsigned sent;
        int unsigned mode;
        int unsigned width;
        int unsigned sign;
        int unsigned length;
        int unsigned per_poly;
        int unsigned count;
        int r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 1);
            sign = $urandom_range(0, 1);
            r = int'($urandom_range(0, 99));
            if (r < 5) width = 0;
            else if (r < 10) width = $urandom_range(18, 31);
            else if (r < 20) width = 17;
            else width = $urandom_range(1, 17);
            r = int'($urandom_range(0, 99));
            if (r < 4) length = 0;
            else if (r < 8) length = $urandom_range(1025, 2047);
            else if (r < 20) length = $urandom_range(41, 300);
            else length = $urandom_range(1, 40);
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            set_stream(mode | ($urandom & 32'h7FE), width | ($urandom & 32'h7E0),
                       sign | ($urandom & 32'h7FE), length);
            per_poly = mode ? (clamp_length(length) * clamp_width(width) + 7) / 8
                            : clamp_length(length);
            count = per_poly * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, 5);
            if (count > 60) count = $urandom_range(30, 60);
            repeat (count) send_word(COEFF_W'($urandom_range(0, 18'h3FFFF)),
                                     BYTE_W'($urandom_range(0, 255)));
            sent += count;
            drain_stream();
        end
    endtask

    initial begin
        mode_unpack = 1'b0;
        reg_width   = 5'd10;
        reg_sign    = 1'b0;
        reg_length  = 11'd512;
        clear_stream();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_pack_extremes();
        test_register_edges();
        test_unpack_extremes();
        test_backpressure();
        test_random_streams();
        drain_stream();
        $display("covered %0d input words and %0d output words over %0d register settings",
                 words_in, words_out, settings_used);
        $display("input held off by a full queue for %0d cycles, %0d mismatches",
                 full_cycles, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
src/cbp_pkg.sv
src/cbp_front.sv
src/cbp_back.sv
src/coefficient_bit_packer.sv
test/testbench.sv
